/* rtl/nsvc_pkg.sv */
// shared constants, types and tables for the nodal surface voxel classifier
// used by nsvc_sincos and the core top level
`timescale 1ns / 1ps

package nsvc_pkg;

    // coordinate and phase widths
    localparam int COORD_BITS = 10;
    localparam int PHASE_BITS = 24;
    localparam int STEP_W     = 24;
    localparam int TYPE_W     = 2;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP   = 2'd1;
    localparam logic [STEP_W-1:0]      PHASE_STEP_RESET = 24'd524288;

    typedef enum logic [TYPE_W-1:0] {
        SURF_GYROID    = 2'd0,
        SURF_DIAMOND   = 2'd1,
        SURF_PRIMITIVE = 2'd2
    } surface_t;

    // cordic datapath
    localparam int TURN_W          = 32;
    localparam int VEC_W           = 33;
    localparam int ANG_W           = 33;
    localparam int CORDIC_STEPS    = 28;
    localparam int STEPS_PER_STAGE = 4;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int CORDIC_GAIN     = 652032874;
    localparam logic [TURN_W-1:0] QUAD_OFFSET = 32'h2000_0000;

    localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5
    };

    // q1.16 results, range -1.0 .. +1.0 inclusive
    localparam int Q_W        = 18;
    localparam int QV_W       = 34;
    localparam int Q16_SHIFT  = 14;
    localparam int ROUND_HALF = 8192;
    localparam int Q16_ONE    = 65536;

    typedef logic signed [Q_W-1:0] q16_t;

    typedef struct packed {
        q16_t c;
        q16_t s;
    } sincos_t;

    // formula widths
    localparam int PROD_W  = 34;
    localparam int SUM_W   = 35;
    localparam int GSUM_W  = 36;
    localparam int PRIM_W  = 20;
    localparam int DPROD_W = 52;
    localparam int DSUM_W  = 53;

    // phase register, sincos pipe, four formula stages
    localparam int SC_LATENCY = CORDIC_STAGES + 1;
    localparam int PIPE_DEPTH = 1 + SC_LATENCY + 4;

endpackage

/* rtl/nsvc_sincos.sv */
// pipelined sine/cosine of a phase word: cordic on the residual angle,
// quadrant fold and rounding to q1.16; depends on nsvc_pkg
`timescale 1ns / 1ps

module nsvc_sincos (
    input  logic                           clk,
    input  logic [nsvc_pkg::PHASE_BITS-1:0] phase,
    output nsvc_pkg::sincos_t              sc
);

    localparam int LAST = nsvc_pkg::CORDIC_STAGES - 1;

    logic [nsvc_pkg::TURN_W-1:0]       turn;
    logic [nsvc_pkg::TURN_W-1:0]       t_off;
    logic [1:0]                        quad0;
    logic signed [nsvc_pkg::ANG_W-1:0] ang0;

    logic signed [nsvc_pkg::VEC_W-1:0] x_reg    [nsvc_pkg::CORDIC_STAGES];
    logic signed [nsvc_pkg::VEC_W-1:0] y_reg    [nsvc_pkg::CORDIC_STAGES];
    logic signed [nsvc_pkg::ANG_W-1:0] ang_reg  [nsvc_pkg::CORDIC_STAGES];
    logic [1:0]                        quad_reg [nsvc_pkg::CORDIC_STAGES];
    logic signed [nsvc_pkg::VEC_W-1:0] x_next   [nsvc_pkg::CORDIC_STAGES];
    logic signed [nsvc_pkg::VEC_W-1:0] y_next   [nsvc_pkg::CORDIC_STAGES];
    logic signed [nsvc_pkg::ANG_W-1:0] ang_next [nsvc_pkg::CORDIC_STAGES];

    logic signed [nsvc_pkg::QV_W-1:0] c_full;
    logic signed [nsvc_pkg::QV_W-1:0] s_full;
    nsvc_pkg::sincos_t                sc_reg;

    function automatic nsvc_pkg::q16_t to_q16(input logic signed [nsvc_pkg::QV_W-1:0] v);
        logic signed [nsvc_pkg::QV_W-1:0] r;
        begin
            r = (v + nsvc_pkg::QV_W'(nsvc_pkg::ROUND_HALF)) >>> nsvc_pkg::Q16_SHIFT;
            if (r > nsvc_pkg::QV_W'(nsvc_pkg::Q16_ONE))
                return nsvc_pkg::Q_W'(nsvc_pkg::Q16_ONE);
            if (r < -nsvc_pkg::QV_W'(nsvc_pkg::Q16_ONE))
                return -nsvc_pkg::Q_W'(nsvc_pkg::Q16_ONE);
            return nsvc_pkg::Q_W'(r);
        end
    endfunction

    // nearest quarter turn and residual in [-1/8, 1/8) turn
    assign turn  = nsvc_pkg::TURN_W'(phase) << (nsvc_pkg::TURN_W - nsvc_pkg::PHASE_BITS);
    assign t_off = turn + nsvc_pkg::QUAD_OFFSET;
    assign quad0 = t_off[nsvc_pkg::TURN_W-1 -: 2];
    assign ang0  = $signed(nsvc_pkg::ANG_W'(t_off[nsvc_pkg::TURN_W-3:0]))
                 - $signed(nsvc_pkg::ANG_W'(nsvc_pkg::QUAD_OFFSET));

    always_comb
    begin : cordic_comb
        logic signed [nsvc_pkg::VEC_W-1:0] xv;
        logic signed [nsvc_pkg::VEC_W-1:0] yv;
        logic signed [nsvc_pkg::VEC_W-1:0] dx;
        logic signed [nsvc_pkg::VEC_W-1:0] dy;
        logic signed [nsvc_pkg::ANG_W-1:0] av;
        for (int s = 0; s < nsvc_pkg::CORDIC_STAGES; s++)
        begin
            if (s == 0)
            begin
                xv = nsvc_pkg::VEC_W'(nsvc_pkg::CORDIC_GAIN);
                yv = '0;
                av = ang0;
            end
            else
            begin
                xv = x_reg[s-1];
                yv = y_reg[s-1];
                av = ang_reg[s-1];
            end
            for (int k = 0; k < nsvc_pkg::STEPS_PER_STAGE; k++)
            begin
                dx = yv >>> (s * nsvc_pkg::STEPS_PER_STAGE + k);
                dy = xv >>> (s * nsvc_pkg::STEPS_PER_STAGE + k);
                if (!av[nsvc_pkg::ANG_W-1])
                begin
                    xv = xv - dx;
                    yv = yv + dy;
                    av = av - nsvc_pkg::ANG_W'(
                        nsvc_pkg::ATAN_TURNS[s * nsvc_pkg::STEPS_PER_STAGE + k]);
                end
                else
                begin
                    xv = xv + dx;
                    yv = yv - dy;
                    av = av + nsvc_pkg::ANG_W'(
                        nsvc_pkg::ATAN_TURNS[s * nsvc_pkg::STEPS_PER_STAGE + k]);
                end
            end
            x_next[s]   = xv;
            y_next[s]   = yv;
            ang_next[s] = av;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < nsvc_pkg::CORDIC_STAGES; s++)
        begin
            x_reg[s]   <= x_next[s];
            y_reg[s]   <= y_next[s];
            ang_reg[s] <= ang_next[s];
            if (s == 0)
                quad_reg[s] <= quad0;
            else
                quad_reg[s] <= quad_reg[s-1];
        end
    end

    // quadrant fold is an exact swap and negate
    always_comb
    begin
        unique case (quad_reg[LAST])
            2'd0:
            begin
                c_full = nsvc_pkg::QV_W'(x_reg[LAST]);
                s_full = nsvc_pkg::QV_W'(y_reg[LAST]);
            end
            2'd1:
            begin
                c_full = -nsvc_pkg::QV_W'(y_reg[LAST]);
                s_full = nsvc_pkg::QV_W'(x_reg[LAST]);
            end
            2'd2:
            begin
                c_full = -nsvc_pkg::QV_W'(x_reg[LAST]);
                s_full = -nsvc_pkg::QV_W'(y_reg[LAST]);
            end
            default:
            begin
                c_full = nsvc_pkg::QV_W'(y_reg[LAST]);
                s_full = -nsvc_pkg::QV_W'(x_reg[LAST]);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sc_reg.c <= to_q16(c_full);
        sc_reg.s <= to_q16(s_full);
    end

    assign sc = sc_reg;

endmodule

/* rtl/nodal_surface_voxel_classifier_core.sv */
// top level of the nodal surface voxel classifier: config registers, phase
// multiply, three nsvc_sincos pipes and the formula stages; depends on nsvc_pkg
`timescale 1ns / 1ps

// Usage
//   Input: present coord_x, coord_y, coord_z with start high; the word is taken
//   at any rising edge where start is high and busy is low. busy stays low, so
//   one voxel can be issued in every cycle.
//   Output: done is high for one cycle with inside_res for each voxel taken.
//   Results leave in issue order, one per voxel.
//   Pipeline: phase multiply register, 7 cordic stages of 4 iterations each,
//   1 quadrant/rounding stage, 4 formula stages (products, sums, triple
//   products, final sum and sign). The cordic chain sets the depth.
//   Throughput: one voxel per cycle, sustained.
//   Config: wr_en with wr_index 0 writes surface_type, index 1 writes
//   phase_step; write only while no voxel is in flight.
//   Reset: rst_n low clears the valid pipe and loads gyroid and a step of
//   524288; words in flight are dropped.
//   Stall: the receiver cannot hold results off, so the pipe never stalls.
module nodal_surface_voxel_classifier_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [nsvc_pkg::COORD_BITS-1:0]  coord_x,
    input  logic [nsvc_pkg::COORD_BITS-1:0]  coord_y,
    input  logic [nsvc_pkg::COORD_BITS-1:0]  coord_z,
    input  logic                             wr_en,
    input  logic [nsvc_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [nsvc_pkg::CFG_DATA_W-1:0]  wr_data,
    output logic                             done,
    output logic                             inside_res
);

    // only the bits below one turn are kept
    localparam int MUL_W = nsvc_pkg::PHASE_BITS;

    logic [nsvc_pkg::TYPE_W-1:0] surface_type_reg;
    logic [nsvc_pkg::STEP_W-1:0] phase_step_reg;
    logic [nsvc_pkg::PIPE_DEPTH-1:0] vld_reg;

    logic [MUL_W-1:0] mul_x, mul_y, mul_z;
    logic [nsvc_pkg::PHASE_BITS-1:0] phase_x_next, phase_y_next, phase_z_next;
    logic [nsvc_pkg::PHASE_BITS-1:0] phase_x_reg, phase_y_reg, phase_z_reg;

    nsvc_pkg::sincos_t sc_x, sc_y, sc_z;

    // stage p1
    logic signed [nsvc_pkg::PROD_W-1:0] g1_reg, g2_reg, g3_reg;
    logic signed [nsvc_pkg::PROD_W-1:0] u1_reg, u2_reg, v1_reg;
    nsvc_pkg::q16_t cz_p1_reg, sz_p1_reg;
    logic signed [nsvc_pkg::PRIM_W-1:0] prim_sum;
    logic prim_neg_p1_reg;
    // stage p2
    logic signed [nsvc_pkg::SUM_W-1:0]  u_reg, v_reg;
    logic signed [nsvc_pkg::GSUM_W-1:0] gyr_sum;
    nsvc_pkg::q16_t cz_p2_reg, sz_p2_reg;
    logic gyr_neg_p2_reg, prim_neg_p2_reg;
    // stage p3
    logic signed [nsvc_pkg::DPROD_W-1:0] du_reg, dv_reg;
    logic gyr_neg_p3_reg, prim_neg_p3_reg;
    // stage p4
    logic signed [nsvc_pkg::DSUM_W-1:0] dia_sum;
    logic inside_next, inside_res_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_type_reg <= nsvc_pkg::SURF_GYROID;
            phase_step_reg   <= nsvc_pkg::PHASE_STEP_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                nsvc_pkg::REG_SURFACE_TYPE:
                    surface_type_reg <= wr_data[nsvc_pkg::TYPE_W-1:0];
                nsvc_pkg::REG_PHASE_STEP:
                    phase_step_reg <= wr_data[nsvc_pkg::STEP_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[nsvc_pkg::PIPE_DEPTH-2:0], start & ~busy};
    end

    // phase = coord * step, modulo one turn
    assign mul_x = MUL_W'(coord_x) * MUL_W'(phase_step_reg);
    assign mul_y = MUL_W'(coord_y) * MUL_W'(phase_step_reg);
    assign mul_z = MUL_W'(coord_z) * MUL_W'(phase_step_reg);
    assign phase_x_next = mul_x;
    assign phase_y_next = mul_y;
    assign phase_z_next = mul_z;

    always_ff @(posedge clk)
    begin
        phase_x_reg <= phase_x_next;
        phase_y_reg <= phase_y_next;
        phase_z_reg <= phase_z_next;
    end

    nsvc_sincos u_sincos_x (.clk(clk), .phase(phase_x_reg), .sc(sc_x));
    nsvc_sincos u_sincos_y (.clk(clk), .phase(phase_y_reg), .sc(sc_y));
    nsvc_sincos u_sincos_z (.clk(clk), .phase(phase_z_reg), .sc(sc_z));

    assign prim_sum = nsvc_pkg::PRIM_W'(sc_x.c) + nsvc_pkg::PRIM_W'(sc_y.c)
                    + nsvc_pkg::PRIM_W'(sc_z.c);

    // p1: pairwise products
    always_ff @(posedge clk)
    begin
        g1_reg <= nsvc_pkg::PROD_W'(sc_y.s) * nsvc_pkg::PROD_W'(sc_z.c);
        g2_reg <= nsvc_pkg::PROD_W'(sc_z.s) * nsvc_pkg::PROD_W'(sc_x.c);
        g3_reg <= nsvc_pkg::PROD_W'(sc_x.s) * nsvc_pkg::PROD_W'(sc_y.c);
        u1_reg <= nsvc_pkg::PROD_W'(sc_x.c) * nsvc_pkg::PROD_W'(sc_y.c);
        u2_reg <= nsvc_pkg::PROD_W'(sc_x.s) * nsvc_pkg::PROD_W'(sc_y.s);
        v1_reg <= nsvc_pkg::PROD_W'(sc_x.c) * nsvc_pkg::PROD_W'(sc_y.s);
        cz_p1_reg <= sc_z.c;
        sz_p1_reg <= sc_z.s;
        prim_neg_p1_reg <= prim_sum[nsvc_pkg::PRIM_W-1];
    end

    assign gyr_sum = nsvc_pkg::GSUM_W'(g1_reg) + nsvc_pkg::GSUM_W'(g2_reg)
                   + nsvc_pkg::GSUM_W'(g3_reg);

    // p2: diamond factors cz*(cx*cy + sx*sy) + sz*(cx*sy + sx*cy) and the gyroid sign
    always_ff @(posedge clk)
    begin
        u_reg <= nsvc_pkg::SUM_W'(u1_reg) + nsvc_pkg::SUM_W'(u2_reg);
        v_reg <= nsvc_pkg::SUM_W'(v1_reg) + nsvc_pkg::SUM_W'(g3_reg);
        cz_p2_reg <= cz_p1_reg;
        sz_p2_reg <= sz_p1_reg;
        gyr_neg_p2_reg  <= gyr_sum[nsvc_pkg::GSUM_W-1];
        prim_neg_p2_reg <= prim_neg_p1_reg;
    end

    // p3: triple products
    always_ff @(posedge clk)
    begin
        du_reg <= nsvc_pkg::DPROD_W'(cz_p2_reg) * nsvc_pkg::DPROD_W'(u_reg);
        dv_reg <= nsvc_pkg::DPROD_W'(sz_p2_reg) * nsvc_pkg::DPROD_W'(v_reg);
        gyr_neg_p3_reg  <= gyr_neg_p2_reg;
        prim_neg_p3_reg <= prim_neg_p2_reg;
    end

    assign dia_sum = nsvc_pkg::DSUM_W'(du_reg) + nsvc_pkg::DSUM_W'(dv_reg);

    always_comb
    begin
        unique case (surface_type_reg)
            nsvc_pkg::SURF_GYROID:    inside_next = gyr_neg_p3_reg;
            nsvc_pkg::SURF_DIAMOND:   inside_next = dia_sum[nsvc_pkg::DSUM_W-1];
            nsvc_pkg::SURF_PRIMITIVE: inside_next = prim_neg_p3_reg;
            default:                  inside_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        inside_res_reg <= inside_next;
    end

    assign inside_res = inside_res_reg;
    assign done       = vld_reg[nsvc_pkg::PIPE_DEPTH-1];

endmodule

/* rtl/nsvc_sva.sv */
// port-level checks for the classifier core: busy, fixed latency in both
// directions; bound to nodal_surface_voxel_classifier_core by port names
`timescale 1ns / 1ps

module nsvc_sva (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // the pipe never stalls, so every start is taken
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised on a stall-free pipe");

    // every accepted word comes back after the fixed latency
    a_word_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##13 done)
        else $error("accepted word did not return after 13 cycles");

    // no result strobe without a word taken at the matching earlier edge
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 13))
        else $error("result strobe without a matching accepted word");

endmodule

bind nodal_surface_voxel_classifier_core nsvc_sva u_nsvc_sva (.*);
